[hdl/dmxrle_pkg.sv]
// ----------------------------------------------------------------------------
// dmxrle_pkg
// Types, codes and byte helpers shared by the frame run-length encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dmxrle_pkg;

  localparam logic [7:0] MARK_RUN = 8'hFE;
  localparam logic [7:0] MARK_ESC = 8'hFD;
  localparam logic [7:0] RUN_MAX  = 8'd255;

  localparam int LEN_W      = 11;
  localparam int SEG_IDX_W  = 3;
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = 1;

  typedef logic [1:0] seg_kind_t;
  localparam seg_kind_t SEG_NONE = 2'd0;
  localparam seg_kind_t SEG_RUN  = 2'd1;
  localparam seg_kind_t SEG_LIT  = 2'd2;
  localparam seg_kind_t SEG_RAW  = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             is_last;
    logic [LEN_W-1:0] payload_length;
  } out_item_t;

  typedef struct packed {
    seg_kind_t  kind;
    logic [7:0] len;
    logic [7:0] val;
  } seg_t;

  typedef struct packed {
    seg_t seg_a;
    seg_t seg_b;
    logic last;
  } cmd_t;

  function automatic seg_t run_seg(input logic [7:0] len, input logic [7:0] val);
    seg_t s;
    s.len = len;
    s.val = val;
    if (len >= 8'd3) begin
      s.kind = SEG_RUN;
    end else if (len != 8'd0) begin
      s.kind = SEG_LIT;
    end else begin
      s.kind = SEG_NONE;
    end
    return s;
  endfunction

  function automatic logic needs_esc(input logic [7:0] val);
    return (val == MARK_RUN) || (val == MARK_ESC);
  endfunction

  // number of payload bytes a segment expands to (literal groups hold at most two)
  function automatic logic [SEG_IDX_W-1:0] seg_bytes(input seg_t s);
    logic [SEG_IDX_W-1:0] n;
    case (s.kind)
      SEG_RUN: n = SEG_IDX_W'(3);
      SEG_LIT: n = needs_esc(s.val) ? {s.len[1:0], 1'b0} : SEG_IDX_W'(s.len[1:0]);
      SEG_RAW: n = SEG_IDX_W'(1);
      default: n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] seg_byte(input seg_t s, input logic [SEG_IDX_W-1:0] idx);
    logic [7:0] b;
    case (s.kind)
      SEG_RUN: begin
        case (idx)
          SEG_IDX_W'(0): b = MARK_RUN;
          SEG_IDX_W'(1): b = s.len;
          default:       b = s.val;
        endcase
      end
      SEG_LIT: b = (needs_esc(s.val) && !idx[0]) ? MARK_ESC : s.val;
      default: b = s.val;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[hdl/dmxrle_front.sv]
// ----------------------------------------------------------------------------
// dmxrle_front
// Tracks the pending run and turns frame bytes into emit commands; bytes that only extend the run emit none.
// ----------------------------------------------------------------------------
`default_nettype none

module dmxrle_front #(
  parameter int FRAME_BYTES = 512
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   use_rle,
  input  wire                   item_take,
  input  dmxrle_pkg::in_item_t  item,
  output logic                  cmd_push,
  output dmxrle_pkg::cmd_t      cmd
);

  localparam int CNT_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  logic [7:0]       run_val_r, run_val_nxt;
  logic [7:0]       run_len_r, run_len_nxt;
  logic [CNT_W-1:0] in_cnt_r, in_cnt_nxt;

  logic       frame_done;
  logic       flush_old;
  logic [7:0] new_len;

  assign frame_done = item.frame_end || (in_cnt_r >= CNT_W'(FRAME_BYTES - 1));
  assign flush_old  = (run_len_r != 8'd0) &&
                      ((run_val_r != item.in_byte) || (run_len_r == dmxrle_pkg::RUN_MAX));
  assign new_len    = (flush_old || (run_len_r == 8'd0)) ? 8'd1 : run_len_r + 8'd1;

  always_comb begin
    cmd.last    = frame_done;
    run_val_nxt = run_val_r;
    run_len_nxt = run_len_r;
    if (use_rle) begin
      cmd.seg_a   = flush_old ? dmxrle_pkg::run_seg(run_len_r, run_val_r)
                              : dmxrle_pkg::run_seg(8'd0, run_val_r);
      cmd.seg_b   = dmxrle_pkg::run_seg(frame_done ? new_len : 8'd0, item.in_byte);
      run_val_nxt = item.in_byte;
      run_len_nxt = frame_done ? 8'd0 : new_len;
    end else begin
      cmd.seg_a      = dmxrle_pkg::run_seg(run_len_r, run_val_r);
      cmd.seg_b.kind = dmxrle_pkg::SEG_RAW;
      cmd.seg_b.len  = 8'd1;
      cmd.seg_b.val  = item.in_byte;
      run_len_nxt    = 8'd0;
    end
  end

  // an item that only extends the run produces no bytes
  assign cmd_push = item_take &&
                    ((cmd.seg_a.kind != dmxrle_pkg::SEG_NONE) ||
                     (cmd.seg_b.kind != dmxrle_pkg::SEG_NONE));

  assign in_cnt_nxt = frame_done ? '0 : in_cnt_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_len_r <= 8'd0;
      run_val_r <= 8'd0;
      in_cnt_r  <= '0;
    end else if (item_take) begin
      run_len_r <= run_len_nxt;
      run_val_r <= run_val_nxt;
      in_cnt_r  <= in_cnt_nxt;
    end
  end

  a_end_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && frame_done |=> run_len_r == 8'd0)
    else $error("run still pending after frame end");

  a_frame_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_cnt_r <= CNT_W'(FRAME_BYTES - 1))
    else $error("frame byte count past frame size");

endmodule

`default_nettype wire

[hdl/dmxrle_cmdq.sv]
// ----------------------------------------------------------------------------
// dmxrle_cmdq
// Short command queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module dmxrle_cmdq (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    wr_en,
  input  dmxrle_pkg::cmd_t       wr_cmd,
  output logic                   q_full,
  input  wire                    rd_en,
  output dmxrle_pkg::cmd_t       rd_cmd,
  output logic                   q_empty
);

  dmxrle_pkg::cmd_t                 slot_r [dmxrle_pkg::CMDQ_DEPTH];
  logic [dmxrle_pkg::CMDQ_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [dmxrle_pkg::CMDQ_AW:0]     cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == (dmxrle_pkg::CMDQ_AW + 1)'(dmxrle_pkg::CMDQ_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_cmd  = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !wr_en || rd_en)
    else $error("command queue overflow");

endmodule

`default_nettype wire

[hdl/dmxrle_back.sv]
// ----------------------------------------------------------------------------
// dmxrle_back
// Expands queued commands into payload bytes and tracks the frame length.
// ----------------------------------------------------------------------------
`default_nettype none

module dmxrle_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    q_empty,
  input  dmxrle_pkg::cmd_t       head,
  output logic                   q_pop,
  input  wire                    pop,
  output logic                   empty,
  output dmxrle_pkg::out_item_t  out_item
);

  logic                                 seg_sel_r, seg_sel_nxt;
  logic [dmxrle_pkg::SEG_IDX_W-1:0]     idx_r, idx_nxt;
  logic [dmxrle_pkg::LEN_W-1:0]         cnt_r, cnt_nxt;
  logic                                 out_vld_r, out_vld_nxt;
  dmxrle_pkg::out_item_t                out_r, out_nxt;

  logic                                 cur_sel;
  dmxrle_pkg::seg_t                     cur_seg;
  logic [dmxrle_pkg::SEG_IDX_W-1:0]     cur_cnt;
  logic                                 seg_last, cmd_done, advance;

  // skip an empty first segment
  assign cur_sel  = seg_sel_r || (head.seg_a.kind == dmxrle_pkg::SEG_NONE);
  assign cur_seg  = cur_sel ? head.seg_b : head.seg_a;
  assign cur_cnt  = dmxrle_pkg::seg_bytes(cur_seg);
  assign seg_last = (idx_r == cur_cnt - 1'b1);
  assign cmd_done = seg_last && (cur_sel || (head.seg_b.kind == dmxrle_pkg::SEG_NONE));
  assign advance  = !q_empty && (!out_vld_r || pop);
  assign q_pop    = advance && cmd_done;

  always_comb begin
    seg_sel_nxt = seg_sel_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r;
    if (pop && out_vld_r) begin
      out_vld_nxt = 1'b0;
    end
    if (advance) begin
      out_vld_nxt      = 1'b1;
      out_nxt.out_byte = dmxrle_pkg::seg_byte(cur_seg, idx_r);
      if (cmd_done && head.last) begin
        out_nxt.is_last        = 1'b1;
        out_nxt.payload_length = cnt_r + dmxrle_pkg::LEN_W'(1);
        cnt_nxt                = '0;
      end else begin
        out_nxt.is_last        = 1'b0;
        out_nxt.payload_length = '0;
        cnt_nxt                = cnt_r + dmxrle_pkg::LEN_W'(1);
      end
      if (cmd_done) begin
        seg_sel_nxt = 1'b0;
        idx_nxt     = '0;
      end else if (seg_last) begin
        seg_sel_nxt = 1'b1;
        idx_nxt     = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_sel_r <= 1'b0;
      idx_r     <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      seg_sel_r <= seg_sel_nxt;
      idx_r     <= idx_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign empty    = !out_vld_r;
  assign out_item = out_r;

  a_idx_in_seg: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> idx_r < cur_cnt)
    else $error("byte index past end of segment");

  a_last_has_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.is_last |-> out_r.payload_length != '0)
    else $error("last byte without payload length");

  a_len_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_r.is_last |-> out_r.payload_length == '0)
    else $error("payload length on a non-final byte");

endmodule

`default_nettype wire

[hdl/dmx_frame_rle_encoder_unit.sv]
// ----------------------------------------------------------------------------
// dmx_frame_rle_encoder_unit
// Frame byte encoder: plain copy or run-length coding with escape bytes.
// ----------------------------------------------------------------------------
// channel  ports                      transfer when
// input    push, full, in_item        push && !full
// result   empty, pop, out_item       pop && !empty
// config   cfg_valid, cfg_ready,      cfg_valid && cfg_ready
//          cfg_use_rle
//
// takes one frame byte per cycle while the command queue has room
// emits one payload byte per cycle while the result is popped; a byte makes zero to six, so the
// output byte port sets the sustained rate
// first payload byte passes through the command queue and the output register to the result ports
// reset is synchronous; plain mode after reset; no clearing pass
// a stalled output fills the two-entry command queue, then full rises
// ----------------------------------------------------------------------------
`default_nettype none

module dmx_frame_rle_encoder_unit #(
  parameter int FRAME_BYTES = 512
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  output logic                   full,
  input  dmxrle_pkg::in_item_t   in_item,
  output logic                   empty,
  input  wire                    pop,
  output dmxrle_pkg::out_item_t  out_item,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire                    cfg_use_rle
);

  logic             use_rle_r;
  logic             item_take;
  logic             cmd_push, q_empty, q_pop;
  dmxrle_pkg::cmd_t cmd_in, cmd_head;

  assign cfg_ready = 1'b1;
  assign item_take = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_rle_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      use_rle_r <= cfg_use_rle;
    end
  end

  dmxrle_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .use_rle   (use_rle_r),
    .item_take (item_take),
    .item      (in_item),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  dmxrle_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_cmd  (cmd_in),
    .q_full  (full),
    .rd_en   (q_pop),
    .rd_cmd  (cmd_head),
    .q_empty (q_empty)
  );

  dmxrle_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .head     (cmd_head),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule

`default_nettype wire
